>>> hw/rtl/lca_pkg.sv
// Shared constants and types for the label centroid accumulator.
`default_nettype none
package lca_pkg;
    localparam int MaxLabels  = 64;
    localparam int MaxWidth   = 4096;
    localparam int MaxHeight  = 4096;
    localparam int LabelW     = $clog2(MaxLabels);
    localparam int CoordW     = $clog2(MaxWidth);
    localparam int RowW       = $clog2(MaxHeight);
    localparam int CfgW       = 13;
    localparam int SumW       = 36;
    localparam int CntW       = 25;
    localparam int MeanW      = 16;
    localparam int QueueDepth = 4;
    localparam logic [CfgW-1:0] WidthReset = CfgW'(640);

    typedef struct packed {
        logic [LabelW-1:0] label;
        logic              in_range;
        logic              frame_end;
        logic [RowW-1:0]   row;
        logic [CoordW-1:0] col;
    } lca_item_t;
endpackage
`default_nettype wire

>>> hw/rtl/label_centroid_accumulator_unit.sv
// Top level of the per-label centroid accumulator.
// Takes a label image in raster order, one 16-bit label per request, with tlast on the
// frame's last pixel. Row and column come from counters driven by image_width (written
// through cfg_wr_en/cfg_wr_data, reset value 640; 0 acts as 1, above 4096 as 4096).
// Labels 0..63 accumulate row sum, column sum and pixel count; larger labels only advance
// the coordinates. After the tlast pixel one result goes out per label from 0 to the
// largest label seen, with mean row and column in unsigned Q12.4 (truncated, held at
// 65535), the count, an empty flag in tuser and tlast on the final result; then the
// store clears. Each pixel's read-modify-write of the label memories takes an idle (read)
// state and an accumulate state in the back end, which takes no new pixel until it is done
// with the last; a 4-entry queue absorbs short bursts. Each label's emission runs through
// read, load, wait and output states, the wait covering the 16-step bit-serial dividers for
// a non-empty, unsaturated label, plus output wait; next-frame pixels queue up meanwhile.
// No clearing pass is needed after reset: per-label valid bits clear at once.
`default_nettype none
module label_centroid_accumulator_unit
    import lca_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    // configuration: image_width
    input  wire logic            cfg_wr_en,
    input  wire logic [CfgW-1:0] cfg_wr_data,
    // pixel stream
    input  wire logic            s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire logic [15:0]     s_axis_tdata,  // [15:0] pixel_label
    input  wire logic            s_axis_tlast,  // frame_end
    // centroid results
    output logic                 m_axis_tvalid,
    input  wire logic            m_axis_tready,
    // [5:0] label_index, [21:6] mean_row, [37:22] mean_col, [62:38] pixel_total, [63] zero
    output logic [63:0]          m_axis_tdata,
    output logic                 m_axis_tuser,  // empty_label
    output logic                 m_axis_tlast   // last_result
);
    lca_item_t         push_item, head_item;
    logic              q_push, q_pop, q_full, q_empty;
    logic [LabelW-1:0] o_label;
    logic [MeanW-1:0]  o_row, o_col;
    logic [CntW-1:0]   o_total;

    lca_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_label(s_axis_tdata), .in_last(s_axis_tlast),
        .q_full(q_full), .q_push(q_push), .q_item(push_item)
    );

    lca_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .push_item(push_item), .full(q_full),
        .pop(q_pop), .head(head_item), .empty(q_empty)
    );

    lca_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_empty(q_empty), .q_head(head_item), .q_pop(q_pop),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_label(o_label), .out_row(o_row), .out_col(o_col),
        .out_total(o_total), .out_empty(m_axis_tuser), .out_last(m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, o_total, o_col, o_row, o_label};
endmodule
`default_nettype wire

>>> hw/rtl/lca_front.sv
// Front end: accepts pixels, tracks raster coordinates, classifies labels.
`default_nettype none
module lca_front
    import lca_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_wr_en,
    input  wire logic [CfgW-1:0] cfg_wr_data,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [15:0]     in_label,
    input  wire logic            in_last,
    input  wire logic            q_full,
    output logic                 q_push,
    output lca_item_t            q_item
);
    logic [CfgW-1:0]   width_reg;
    logic [CfgW-1:0]   width_eff;
    logic [CoordW-1:0] col_reg, col_next, col_inc;
    logic [RowW-1:0]   row_reg, row_next;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb begin
        if (width_reg == '0) begin
            width_eff = CfgW'(1);
        end else if (width_reg > CfgW'(MaxWidth)) begin
            width_eff = CfgW'(MaxWidth);
        end else begin
            width_eff = width_reg;
        end
        col_inc  = col_reg + 1'b1;
        col_next = col_inc;
        row_next = row_reg;
        if (({1'b0, col_inc} >= width_eff) || (col_inc == '0)) begin
            col_next = '0;
            if (row_reg < RowW'(MaxHeight - 1)) begin
                row_next = row_reg + 1'b1;
            end
        end
        q_item.label     = in_label[LabelW-1:0];
        q_item.in_range  = (in_label < 16'(MaxLabels));
        q_item.frame_end = in_last;
        q_item.row       = row_reg;
        q_item.col       = col_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= WidthReset;
            col_reg   <= '0;
            row_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                width_reg <= cfg_wr_data;
            end
            if (q_push) begin
                if (in_last) begin
                    col_reg <= '0;
                    row_reg <= '0;
                end else begin
                    col_reg <= col_next;
                    row_reg <= row_next;
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/lca_queue.sv
// Small FIFO between front and back ends.
`default_nettype none
module lca_queue
    import lca_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire lca_item_t push_item,
    output logic           full,
    input  wire logic      pop,
    output lca_item_t      head,
    output logic           empty
);
    localparam int PtrW = $clog2(QueueDepth);
    lca_item_t         store [QueueDepth];
    logic [PtrW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PtrW:0]     fill_reg;

    assign full  = (fill_reg == (PtrW+1)'(QueueDepth));
    assign empty = (fill_reg == '0);
    assign head  = store[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            store[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/lca_div.sv
// Restoring divider for (sum * 16) / count, one quotient bit per cycle, saturating.
`default_nettype none
module lca_div
    import lca_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            start,
    input  wire logic [SumW-1:0] sum,
    input  wire logic [CntW-1:0] cnt,
    output logic                 busy,
    output logic [MeanW-1:0]     quot
);
    localparam int RemW = SumW + 4;
    localparam int StepW = $clog2(MeanW);
    logic [RemW-1:0]  rem_reg;
    logic [RemW-1:0]  dvs_reg;
    logic [MeanW-1:0] quot_reg;
    logic [StepW-1:0] step_reg;
    logic             busy_reg;
    logic [RemW-1:0]  dividend;
    logic             overflow;

    assign dividend = {sum, 4'b0000};
    assign overflow = ({1'b0, dividend} >= {cnt, {MeanW{1'b0}}});
    assign busy     = busy_reg;
    assign quot     = quot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= !(cnt == '0 || overflow);
        end else if (busy_reg && step_reg == '0) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= dividend;
            dvs_reg  <= RemW'({cnt, {(MeanW-1){1'b0}}});
            step_reg <= StepW'(MeanW - 1);
            quot_reg <= (cnt == '0) ? '0 : (overflow ? '1 : '0);
        end else if (busy_reg) begin
            if (rem_reg >= dvs_reg) begin
                rem_reg  <= rem_reg - dvs_reg;
                quot_reg <= {quot_reg[MeanW-2:0], 1'b1};
            end else begin
                quot_reg <= {quot_reg[MeanW-2:0], 1'b0};
            end
            dvs_reg  <= dvs_reg >> 1;
            step_reg <= step_reg - 1'b1;
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/lca_back.sv
// Back end: per-label accumulation memories and end-of-frame centroid emission.
`default_nettype none
module lca_back
    import lca_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_empty,
    input  wire lca_item_t         q_head,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [LabelW-1:0]      out_label,
    output logic [MeanW-1:0]       out_row,
    output logic [MeanW-1:0]       out_col,
    output logic [CntW-1:0]        out_total,
    output logic                   out_empty,
    output logic                   out_last
);
    typedef enum logic [2:0] {
        B_IDLE, B_ACC, E_READ, E_LOAD, E_WAIT, E_OUT
    } state_t;

    state_t            state_reg;
    lca_item_t         item_reg;
    logic [SumW-1:0]   row_mem [MaxLabels];
    logic [SumW-1:0]   col_mem [MaxLabels];
    logic [CntW-1:0]   cnt_mem [MaxLabels];
    logic [MaxLabels-1:0] vld_reg;
    logic [SumW-1:0]   rd_row_reg, rd_col_reg;
    logic [CntW-1:0]   rd_cnt_reg;
    logic              rd_vld_reg;
    logic [LabelW-1:0] rd_addr;
    logic [LabelW-1:0] emit_idx_reg;
    logic [LabelW-1:0] largest_reg;
    logic [SumW-1:0]   cur_row, cur_col, new_row, new_col;
    logic [CntW-1:0]   cur_cnt, new_cnt;
    logic [SumW:0]     row_add, col_add;
    logic              wr_en;
    logic              div_start;
    logic              row_busy, col_busy;
    logic [MeanW-1:0]  row_q, col_q;

    assign rd_addr   = (state_reg == B_IDLE) ? q_head.label : emit_idx_reg;
    assign q_pop     = (state_reg == B_IDLE) && !q_empty;
    assign div_start = (state_reg == E_LOAD);
    assign out_valid = (state_reg == E_OUT);

    always_comb begin
        cur_row = rd_vld_reg ? rd_row_reg : '0;
        cur_col = rd_vld_reg ? rd_col_reg : '0;
        cur_cnt = rd_vld_reg ? rd_cnt_reg : '0;
        row_add = {1'b0, cur_row} + (SumW+1)'(item_reg.row);
        col_add = {1'b0, cur_col} + (SumW+1)'(item_reg.col);
        new_row = row_add[SumW] ? '1 : row_add[SumW-1:0];
        new_col = col_add[SumW] ? '1 : col_add[SumW-1:0];
        new_cnt = (cur_cnt == '1) ? cur_cnt : cur_cnt + 1'b1;
        wr_en   = (state_reg == B_ACC) && item_reg.in_range;
    end

    // Memories: one write port, registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            row_mem[item_reg.label] <= new_row;
            col_mem[item_reg.label] <= new_col;
            cnt_mem[item_reg.label] <= new_cnt;
        end
        rd_row_reg <= row_mem[rd_addr];
        rd_col_reg <= col_mem[rd_addr];
        rd_cnt_reg <= cnt_mem[rd_addr];
    end

    lca_div u_div_row (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .sum(cur_row), .cnt(cur_cnt), .busy(row_busy), .quot(row_q)
    );
    lca_div u_div_col (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .sum(cur_col), .cnt(cur_cnt), .busy(col_busy), .quot(col_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            vld_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            largest_reg  <= '0;
            emit_idx_reg <= '0;
        end else begin
            rd_vld_reg <= vld_reg[rd_addr];
            case (state_reg)
                B_IDLE: begin
                    if (!q_empty) begin
                        item_reg  <= q_head;
                        state_reg <= B_ACC;
                    end
                end
                B_ACC: begin
                    if (item_reg.in_range) begin
                        vld_reg[item_reg.label] <= 1'b1;
                        if (item_reg.label > largest_reg) begin
                            largest_reg <= item_reg.label;
                        end
                    end
                    if (item_reg.frame_end) begin
                        emit_idx_reg <= '0;
                        state_reg    <= E_READ;
                    end else begin
                        state_reg <= B_IDLE;
                    end
                end
                E_READ: state_reg <= E_LOAD;
                E_LOAD: state_reg <= E_WAIT;
                E_WAIT: begin
                    if (!row_busy && !col_busy) begin
                        out_label <= emit_idx_reg;
                        out_row   <= row_q;
                        out_col   <= col_q;
                        out_total <= cur_cnt;
                        out_empty <= (cur_cnt == '0);
                        out_last  <= (emit_idx_reg == largest_reg);
                        state_reg <= E_OUT;
                    end
                end
                E_OUT: begin
                    if (out_ready) begin
                        if (emit_idx_reg == largest_reg) begin
                            vld_reg     <= '0;
                            largest_reg <= '0;
                            state_reg   <= B_IDLE;
                        end else begin
                            emit_idx_reg <= emit_idx_reg + 1'b1;
                            state_reg    <= E_READ;
                        end
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/lca_checker.sv
// Port-level checks for the centroid accumulator, bound to the top level.
`default_nettype none
module lca_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic        m_axis_tuser,
    input wire logic        m_axis_tlast
);
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[63:6] == '0)
        else $error("empty label with nonzero fields");

    a_nonempty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[62:38] != '0)
        else $error("non-empty label with zero count");
endmodule

bind label_centroid_accumulator_unit lca_checker u_lca_checker (
    .aclk(aclk), .aresetn(aresetn),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
